// ===== src/assert_macros.svh =====
// Assertion macros used by the entry store of the key/value cache.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
	else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ===== src/lkvc_pkg.sv =====
// Types and constants of the LRU key/value cache.
`timescale 1ns / 1ps
package lkvc_pkg;
	localparam int CAP_W = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
	localparam logic [31:0] READ_MISS = 32'hFFFF_FFFF;
	localparam logic [31:0] READ_ZERO = 32'h0000_0000;

	typedef enum logic [0:0] {
		OP_GET = 1'b0,
		OP_SET = 1'b1
	} op_t;

	typedef struct packed {
		logic        fire;
		op_t         op;
		logic [31:0] key;
		logic [31:0] value;
	} req_t;

	typedef struct packed {
		logic        hit;
		logic [31:0] read_value;
		logic        evicted;
	} resp_t;
endpackage

// ===== src/lru_key_value_cache_unit.sv =====
// Top level of the fully associative key/value cache with LRU replacement.
//
//  channel  direction  handshake             beat contents
//  in       into       in_valid / in_stall   opcode, key, value
//  out      out of     out_valid / out_stall hit, read_value, evicted
//  cfg      into       cfg_valid / cfg_ready cfg_data (capacity)
//
// One item is taken every cycle while in_stall is low; its result passes through an input
// register and a result register before it is offered on the out channel.
// The lookup, rank update and insert of an item all happen in the cycle it
// leaves the input register, so the next item sees the updated entries.
// Reset clears the valid bits, ranks and entry count at once; no sweep is needed.
// A stalled result holds; one more item can wait in the input register meanwhile.
`timescale 1ns / 1ps
module lru_key_value_cache_unit #(
	parameter int MAX_ENTRIES = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       opcode,
	input  logic [31:0]                key,
	input  logic [31:0]                value,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       hit,
	output logic [31:0]                read_value,
	output logic                       evicted,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [lkvc_pkg::CAP_W-1:0] cfg_data
);
	logic                       valid_s1;
	logic                       opcode_s1;
	logic [31:0]                key_s1;
	logic [31:0]                value_s1;
	logic [lkvc_pkg::CAP_W-1:0] capacity_q;
	logic                       out_valid_q;
	logic                       hit_q;
	logic [31:0]                read_value_q;
	logic                       evicted_q;
	logic                       proc;
	logic                       take;
	lkvc_pkg::req_t             req;
	lkvc_pkg::resp_t            resp;

	assign proc = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !proc;
	assign take = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	assign req.fire = proc;
	assign req.op = lkvc_pkg::op_t'(opcode_s1);
	assign req.key = key_s1;
	assign req.value = value_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
			capacity_q <= lkvc_pkg::CAP_RESET;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (proc) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				capacity_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			opcode_s1 <= opcode;
			key_s1 <= key;
			value_s1 <= value;
		end
		if (proc) begin
			hit_q <= resp.hit;
			read_value_q <= resp.read_value;
			evicted_q <= resp.evicted;
		end
	end

	lkvc_store #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.capacity(capacity_q),
		.req     (req),
		.resp    (resp)
	);

	assign out_valid = out_valid_q;
	assign hit = hit_q;
	assign read_value = read_value_q;
	assign evicted = evicted_q;
endmodule

// ===== src/lkvc_store.sv =====
// Entry store of the cache: key compare, recency ranks, eviction and insert.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lkvc_store #(
	parameter int MAX_ENTRIES = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [lkvc_pkg::CAP_W-1:0] capacity,
	input  lkvc_pkg::req_t             req,
	output lkvc_pkg::resp_t            resp
);
	localparam int RANK_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int CMP_W = (CNT_W > lkvc_pkg::CAP_W) ? CNT_W : lkvc_pkg::CAP_W;

	logic [31:0]            keys_q   [MAX_ENTRIES];
	logic [31:0]            values_q [MAX_ENTRIES];
	logic [RANK_W-1:0]      rank_q   [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0] valid_q;
	logic [CNT_W-1:0]       count_q;

	logic [MAX_ENTRIES-1:0] match;
	logic [MAX_ENTRIES-1:0] victim;
	logic [MAX_ENTRIES-1:0] kept;
	logic [MAX_ENTRIES-1:0] free;
	logic [MAX_ENTRIES-1:0] slot;
	logic                   hit;
	logic [RANK_W-1:0]      hit_rank;
	logic [31:0]            hit_value;
	logic [RANK_W-1:0]      last_rank;
	logic [CMP_W-1:0]       cap_ext;
	logic [CMP_W-1:0]       max_ext;
	logic [CMP_W-1:0]       count_ext;
	logic [CMP_W-1:0]       eff_cap;
	logic                   is_set;
	logic                   do_insert;
	logic                   do_evict;

	always_comb begin
		hit_rank = '0;
		hit_value = '0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			match[i] = valid_q[i] && (keys_q[i] == req.key);
			if (match[i]) begin
				hit_rank = hit_rank | rank_q[i];
				hit_value = hit_value | values_q[i];
			end
		end
		hit = |match;

		cap_ext = CMP_W'(capacity);
		max_ext = CMP_W'(MAX_ENTRIES);
		count_ext = CMP_W'(count_q);
		if (cap_ext == '0) begin
			eff_cap = CMP_W'(1);
		end else if (cap_ext > max_ext) begin
			eff_cap = max_ext;
		end else begin
			eff_cap = cap_ext;
		end

		is_set = (req.op == lkvc_pkg::OP_SET);
		do_insert = is_set && !hit;
		do_evict = do_insert && (count_ext >= eff_cap) && (count_q != '0);
		last_rank = RANK_W'(count_q - CNT_W'(1));

		for (int i = 0; i < MAX_ENTRIES; i++) begin
			victim[i] = do_evict && valid_q[i] && (rank_q[i] == last_rank);
		end
		kept = valid_q & ~victim;
		// The lowest free entry takes the new key.
		free = ~kept;
		slot = free & (~free + MAX_ENTRIES'(1));

		resp.hit = hit;
		resp.evicted = do_evict;
		if (is_set) begin
			resp.read_value = lkvc_pkg::READ_ZERO;
		end else if (hit) begin
			resp.read_value = hit_value;
		end else begin
			resp.read_value = lkvc_pkg::READ_MISS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				rank_q[i] <= '0;
			end
		end else if (req.fire) begin
			if (hit) begin
				for (int i = 0; i < MAX_ENTRIES; i++) begin
					if (match[i]) begin
						rank_q[i] <= '0;
					end else if (valid_q[i] && (rank_q[i] < hit_rank)) begin
						rank_q[i] <= rank_q[i] + RANK_W'(1);
					end
				end
			end else if (is_set) begin
				for (int i = 0; i < MAX_ENTRIES; i++) begin
					if (slot[i]) begin
						rank_q[i] <= '0;
						valid_q[i] <= 1'b1;
					end else if (kept[i]) begin
						rank_q[i] <= rank_q[i] + RANK_W'(1);
					end else if (victim[i]) begin
						rank_q[i] <= '0;
						valid_q[i] <= 1'b0;
					end
				end
				if (!do_evict) begin
					count_q <= count_q + CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			if (req.fire && is_set && (match[i] || (do_insert && slot[i]))) begin
				values_q[i] <= req.value;
			end
			if (req.fire && do_insert && slot[i]) begin
				keys_q[i] <= req.key;
			end
		end
	end

	`ASSERT_PROP(a_match_unique, clk, arst_n, $onehot0(match))
	`ASSERT_PROP(a_count_tracks_valid, clk, arst_n, $countones(valid_q) == count_q)
	`ASSERT_PROP(a_one_victim, clk, arst_n, do_evict |-> $onehot(victim))
	`ASSERT_NEVER(a_count_bound, clk, arst_n, count_ext > max_ext)
endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the LRU key/value cache: directed table, random traffic, checking.
`timescale 1ns / 1ps
module testbench;
	localparam int MAX_SLOTS = 16;

	typedef struct {
		bit                         is_cfg;
		logic [lkvc_pkg::CAP_W-1:0] cap;
		lkvc_pkg::op_t              op;
		logic [31:0]                k;
		logic [31:0]                v;
		bit                         typed;
		lkvc_pkg::resp_t            exp;
	} step_row_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       in_valid = 1'b0;
	logic                       in_stall;
	logic                       opcode = 1'b0;
	logic [31:0]                key = '0;
	logic [31:0]                value = '0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic                       hit;
	logic [31:0]                read_value;
	logic                       evicted;
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic [lkvc_pkg::CAP_W-1:0] cfg_data = '0;

	logic [31:0]                slot_key[MAX_SLOTS];
	logic [31:0]                slot_value[MAX_SLOTS];
	bit                         slot_live[MAX_SLOTS];
	int                         slot_age[MAX_SLOTS];
	int                         live_count = 0;
	logic [lkvc_pkg::CAP_W-1:0] capacity_reg = lkvc_pkg::CAP_RESET;

	lkvc_pkg::resp_t            expected_results[$];
	int                         errors = 0;
	int                         received = 0;
	int                         hit_count = 0;
	int                         evict_count = 0;
	int                         cap_writes = 0;
	bit                         no_idle = 1'b0;

	lru_key_value_cache_unit #(.MAX_ENTRIES(MAX_SLOTS)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.key(key),
		.value(value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.hit(hit),
		.read_value(read_value),
		.evicted(evicted),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int usable_slots();
		if (capacity_reg == 0)
			return 1;
		if (capacity_reg > MAX_SLOTS)
			return MAX_SLOTS;
		return int'(capacity_reg);
	endfunction

	function automatic lkvc_pkg::resp_t cache_access(lkvc_pkg::op_t op, logic [31:0] k,
			logic [31:0] v);
		lkvc_pkg::resp_t r;
		int found;
		int slot;
		int old;
		int i;
		r.hit = 1'b0;
		r.read_value = lkvc_pkg::READ_ZERO;
		r.evicted = 1'b0;
		found = -1;
		slot = -1;
		for (i = 0; i < MAX_SLOTS; i++)
			if (found < 0 && slot_live[i] && slot_key[i] == k)
				found = i;
		if (found >= 0) begin
			r.hit = 1'b1;
			if (op == lkvc_pkg::OP_GET)
				r.read_value = slot_value[found];
			else
				slot_value[found] = v;
			old = slot_age[found];
			for (i = 0; i < MAX_SLOTS; i++)
				if (slot_live[i] && slot_age[i] < old)
					slot_age[i]++;
			slot_age[found] = 0;
		end else if (op == lkvc_pkg::OP_GET) begin
			r.read_value = lkvc_pkg::READ_MISS;
		end else begin
			if (live_count >= usable_slots() && live_count > 0) begin
				for (i = 0; i < MAX_SLOTS; i++) begin
					if (!r.evicted && slot_live[i] && slot_age[i] == live_count - 1) begin
						slot_live[i] = 1'b0;
						slot_age[i] = 0;
						live_count--;
						r.evicted = 1'b1;
					end
				end
			end
			for (i = 0; i < MAX_SLOTS; i++)
				if (slot < 0 && !slot_live[i])
					slot = i;
			if (slot >= 0) begin
				for (i = 0; i < MAX_SLOTS; i++)
					if (slot_live[i])
						slot_age[i]++;
				slot_live[slot] = 1'b1;
				slot_key[slot] = k;
				slot_value[slot] = v;
				slot_age[slot] = 0;
				live_count++;
			end
		end
		return r;
	endfunction

	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 11))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return 32'h8000_0000;
			3: return 32'h7FFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	function automatic step_row_t row_chk(lkvc_pkg::op_t op, logic [31:0] k, logic [31:0] v,
			logic h, logic [31:0] rd, logic ev);
		step_row_t row;
		row.is_cfg = 1'b0;
		row.cap = '0;
		row.op = op;
		row.k = k;
		row.v = v;
		row.typed = 1'b1;
		row.exp.hit = h;
		row.exp.read_value = rd;
		row.exp.evicted = ev;
		return row;
	endfunction

	function automatic step_row_t row_op(lkvc_pkg::op_t op, logic [31:0] k, logic [31:0] v);
		step_row_t row;
		row = row_chk(op, k, v, 1'b0, lkvc_pkg::READ_ZERO, 1'b0);
		row.typed = 1'b0;
		return row;
	endfunction

	function automatic step_row_t row_cfg(logic [lkvc_pkg::CAP_W-1:0] c);
		step_row_t row;
		row = row_op(lkvc_pkg::OP_GET, '0, '0);
		row.is_cfg = 1'b1;
		row.cap = c;
		return row;
	endfunction

	function automatic void log_expected(lkvc_pkg::resp_t r);
		expected_results.insert(expected_results.size(), r);
	endfunction

	task automatic send_item(lkvc_pkg::op_t op, logic [31:0] k, logic [31:0] v, int gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		key <= k;
		value <= v;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic set_capacity(logic [lkvc_pkg::CAP_W-1:0] c);
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= c;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		capacity_reg = c;
		cap_writes++;
	endtask

	task automatic report(string field, logic [31:0] want, logic [31:0] got);
		errors++;
		$display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
	endtask

	initial begin : stimulus
		step_row_t plan[$];
		step_row_t row;
		lkvc_pkg::resp_t guess;
		logic [31:0] key_pool[32];
		int pool_n;
		int cap;
		int p;
		int j;
		lkvc_pkg::op_t op;
		logic [31:0] k;
		logic [31:0] v;
		plan = '{
			row_chk(lkvc_pkg::OP_GET, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0,
				lkvc_pkg::READ_MISS, 1'b0),
			row_chk(lkvc_pkg::OP_SET, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0,
				lkvc_pkg::READ_ZERO, 1'b0),
			row_chk(lkvc_pkg::OP_GET, 32'h8000_0000, 32'h0000_0000, 1'b1,
				32'h7FFF_FFFF, 1'b0),
			row_chk(lkvc_pkg::OP_SET, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0,
				lkvc_pkg::READ_ZERO, 1'b0),
			row_chk(lkvc_pkg::OP_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1,
				32'h8000_0000, 1'b0),
			row_chk(lkvc_pkg::OP_SET, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1,
				lkvc_pkg::READ_ZERO, 1'b0),
			row_chk(lkvc_pkg::OP_GET, 32'h8000_0000, 32'h0000_0000, 1'b1,
				32'hFFFF_FFFF, 1'b0),
			row_chk(lkvc_pkg::OP_GET, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0,
				lkvc_pkg::READ_MISS, 1'b0),
			row_chk(lkvc_pkg::OP_SET, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0,
				lkvc_pkg::READ_ZERO, 1'b0),
			row_chk(lkvc_pkg::OP_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
				32'h0000_0000, 1'b0),
			row_cfg(5'd2),
			row_op(lkvc_pkg::OP_SET, 32'd5, 32'd55),
			row_op(lkvc_pkg::OP_GET, 32'h7FFF_FFFF, 32'd0),
			row_op(lkvc_pkg::OP_SET, 32'd6, 32'd66),
			row_op(lkvc_pkg::OP_GET, 32'd5, 32'd0),
			row_cfg(5'd0),
			row_op(lkvc_pkg::OP_SET, 32'd7, 32'd77),
			row_op(lkvc_pkg::OP_GET, 32'd6, 32'd0),
			row_op(lkvc_pkg::OP_GET, 32'd7, 32'd0),
			row_cfg(5'd31),
			row_op(lkvc_pkg::OP_SET, 32'd100, 32'h5555_5555),
			row_op(lkvc_pkg::OP_SET, 32'd101, 32'hAAAA_AAAA),
			row_op(lkvc_pkg::OP_SET, 32'd102, 32'd2),
			row_op(lkvc_pkg::OP_GET, 32'd100, 32'd0),
			row_cfg(5'd1),
			row_op(lkvc_pkg::OP_SET, 32'd200, 32'd1),
			row_op(lkvc_pkg::OP_SET, 32'd200, 32'd2),
			row_op(lkvc_pkg::OP_GET, 32'd200, 32'd0)
		};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (plan[n]) begin
			row = plan[n];
			if (row.is_cfg) begin
				set_capacity(row.cap);
			end else begin
				send_item(row.op, row.k, row.v, $urandom_range(0, 10));
				guess = cache_access(row.op, row.k, row.v);
				log_expected(row.typed ? row.exp : guess);
			end
		end
		for (p = 0; p < 8; p++) begin
			case (p)
				0: cap = 5;
				1: cap = 16;
				2: cap = 1;
				3: cap = 0;
				4: cap = 31;
				5: cap = 3;
				6: cap = $urandom_range(2, 15);
				default: cap = 12;
			endcase
			set_capacity(cap[lkvc_pkg::CAP_W-1:0]);
			no_idle = (p % 3 == 2);
			pool_n = usable_slots() + $urandom_range(1, 6);
			for (j = 0; j < pool_n; j++)
				key_pool[j] = pick_word();
			repeat (50) begin
				op = lkvc_pkg::op_t'($urandom_range(0, 1));
				if ($urandom_range(0, 7) == 0)
					k = pick_word();
				else
					k = key_pool[$urandom_range(0, pool_n - 1)];
				v = pick_word();
				send_item(op, k, v, no_idle ? 0 : $urandom_range(0, 10));
				log_expected(cache_access(op, k, v));
			end
		end
		no_idle = 1'b0;
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		$display("Checked %0d accesses: %0d hits, %0d evictions, %0d capacity writes.",
			received, hit_count, evict_count, cap_writes);
		if (errors == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

	initial begin : drain
		int gap;
		lkvc_pkg::resp_t want;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = no_idle ? 0 : $urandom_range(0, 10);
			// A long hold-off here backs the pipeline up into the input.
			if (received == 100)
				gap = 60;
			if (gap > 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(posedge clk);
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (!out_valid);
			received++;
			hit_count += hit;
			evict_count += evicted;
			if (expected_results.size() == 0) begin
				errors++;
				$display("%0t: result beat with nothing expected, hit %b value %h evicted %b",
					$time, hit, read_value, evicted);
			end else begin
				want = expected_results.pop_front();
				if (hit !== want.hit)
					report("hit", want.hit, hit);
				if (read_value !== want.read_value)
					report("read_value", want.read_value, read_value);
				if (evicted !== want.evicted)
					report("evicted", want.evicted, evicted);
			end
		end
	end

	initial begin : watchdog
		#2_000_000;
		$display("Timed out with %0d results outstanding.", expected_results.size());
		$display("testbench NOT OK");
		$finish;
	end
endmodule

// ===== sim.f =====
+incdir+src
src/lkvc_pkg.sv
src/lkvc_store.sv
src/lru_key_value_cache_unit.sv
tb/testbench.sv
